@@ rtl/cpfc_pkg.sv @@
package cpfc_pkg;

	typedef enum logic [1:0] {
		FMT_YUV422 = 2'd0,
		FMT_RGB555 = 2'd1,
		FMT_RGB888 = 2'd2
	} fmt_t;

	typedef enum logic {
		CFG_SOURCE_FORMAT = 1'b0,
		CFG_GRAY_OUTPUT   = 1'b1
	} cfg_idx_t;

	localparam int unsigned PixW  = 24;
	localparam int unsigned ChanW = 8;
	localparam int unsigned CfgW  = 2;
	localparam int unsigned AccW  = 21;

	localparam logic signed [AccW-1:0] CoefRv = 21'sd1404;
	localparam logic signed [AccW-1:0] CoefGv = 21'sd715;
	localparam logic signed [AccW-1:0] CoefGu = 21'sd344;
	localparam logic signed [AccW-1:0] CoefBu = 21'sd1774;

	localparam logic [ChanW-1:0] YMin = 8'd16;
	localparam logic [ChanW-1:0] YMax = 8'd235;
	localparam logic [ChanW-1:0] ChanMax = 8'hFF;

	typedef struct packed {
		logic [ChanW-1:0] gray;
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} pixel_t;

endpackage

@@ rtl/cpfc_lane.sv @@
module cpfc_lane (
	input  logic                         clk,
	input  logic                         load,
	input  logic [cpfc_pkg::PixW-1:0]    word,
	input  logic [cpfc_pkg::ChanW-1:0]   u_byte,
	input  logic [cpfc_pkg::ChanW-1:0]   v_byte,
	input  cpfc_pkg::fmt_t               fmt,
	input  logic                         gray,
	output cpfc_pkg::pixel_t             pix
);

	localparam int unsigned AW = cpfc_pkg::AccW;
	localparam int unsigned CW = cpfc_pkg::ChanW;

	logic [CW-1:0]        y_clamp;
	logic signed [CW-1:0] u_sgn;
	logic signed [CW-1:0] v_sgn;
	logic signed [AW-1:0] u_ext;
	logic signed [AW-1:0] v_ext;

	logic signed [AW-1:0] s_s1;
	logic signed [AW-1:0] rv_s1;
	logic signed [AW-1:0] gv_s1;
	logic signed [AW-1:0] gu_s1;
	logic signed [AW-1:0] bu_s1;
	logic [cpfc_pkg::PixW-1:0] word_s1;

	logic signed [AW-1:0] sum_r;
	logic signed [AW-1:0] sum_g;
	logic signed [AW-1:0] sum_b;
	logic [15:0]          w16;

	function automatic logic [CW-1:0] to_chan(input logic signed [AW-1:0] x);
		logic [CW-1:0] res;
		if (x[AW-1]) begin
			res = '0;
		end else if (x[AW-2:10] > {{(AW-2-10+1-CW){1'b0}}, cpfc_pkg::ChanMax}) begin
			res = cpfc_pkg::ChanMax;
		end else begin
			res = x[CW+9:10];
		end
		return res;
	endfunction

	// byte minus 128 is the byte with its top bit flipped
	assign u_sgn = {~u_byte[CW-1], u_byte[CW-2:0]};
	assign v_sgn = {~v_byte[CW-1], v_byte[CW-2:0]};
	assign u_ext = {{(AW-CW){u_sgn[CW-1]}}, u_sgn};
	assign v_ext = {{(AW-CW){v_sgn[CW-1]}}, v_sgn};

	always_comb begin
		if (word[CW-1:0] < cpfc_pkg::YMin) begin
			y_clamp = cpfc_pkg::YMin;
		end else if (word[CW-1:0] > cpfc_pkg::YMax) begin
			y_clamp = cpfc_pkg::YMax;
		end else begin
			y_clamp = word[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			s_s1    <= {{(AW-CW-10){1'b0}}, y_clamp, 10'b0};
			rv_s1   <= v_ext * cpfc_pkg::CoefRv;
			gv_s1   <= v_ext * cpfc_pkg::CoefGv;
			gu_s1   <= u_ext * cpfc_pkg::CoefGu;
			bu_s1   <= u_ext * cpfc_pkg::CoefBu;
			word_s1 <= word;
		end
	end

	assign sum_r = s_s1 + rv_s1;
	assign sum_g = s_s1 - gv_s1 - gu_s1;
	assign sum_b = s_s1 + bu_s1;
	assign w16   = word_s1[15:0];

	always_comb begin
		pix = '0;
		case (fmt)
			cpfc_pkg::FMT_YUV422: begin
				if (gray) begin
					pix.gray = w16[7:0];
				end else begin
					pix.red   = to_chan(sum_r);
					pix.green = to_chan(sum_g);
					pix.blue  = to_chan(sum_b);
				end
			end
			cpfc_pkg::FMT_RGB555: begin
				if (gray) begin
					pix.gray = {w16[14:10], 3'b0};
				end else begin
					pix.red   = {w16[14:10], 3'b0};
					pix.green = {w16[9:5], 3'b0};
					pix.blue  = {w16[4:0], 3'b0};
				end
			end
			cpfc_pkg::FMT_RGB888: begin
				if (gray) begin
					pix.gray = word_s1[7:0];
				end else begin
					pix.blue  = word_s1[7:0];
					pix.green = word_s1[15:8];
					pix.red   = word_s1[23:16];
				end
			end
			default: begin
				pix = '0;
			end
		endcase
	end

endmodule

@@ rtl/cpfc_merge.sv @@
module cpfc_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s1_valid,
	input  cpfc_pkg::pixel_t           pix_first,
	input  cpfc_pkg::pixel_t           pix_second,
	input  logic                       out_stall,
	output logic                       s2_free,
	output logic                       out_valid,
	output logic [cpfc_pkg::ChanW-1:0] blue_first,
	output logic [cpfc_pkg::ChanW-1:0] green_first,
	output logic [cpfc_pkg::ChanW-1:0] red_first,
	output logic [cpfc_pkg::ChanW-1:0] blue_second,
	output logic [cpfc_pkg::ChanW-1:0] green_second,
	output logic [cpfc_pkg::ChanW-1:0] red_second,
	output logic [cpfc_pkg::ChanW-1:0] gray_first,
	output logic [cpfc_pkg::ChanW-1:0] gray_second
);

	logic             valid_s2;
	cpfc_pkg::pixel_t first_s2;
	cpfc_pkg::pixel_t second_s2;

	assign s2_free = !valid_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_valid) begin
			first_s2  <= pix_first;
			second_s2 <= pix_second;
		end
	end

	assign out_valid    = valid_s2;
	assign blue_first   = first_s2.blue;
	assign green_first  = first_s2.green;
	assign red_first    = first_s2.red;
	assign gray_first   = first_s2.gray;
	assign blue_second  = second_s2.blue;
	assign green_second = second_s2.green;
	assign red_second   = second_s2.red;
	assign gray_second  = second_s2.gray;

endmodule

@@ rtl/capture_pixel_format_converter_unit.sv @@
// Converts one pair of adjacent capture pixels per item into two 8-bit BGR pixels or two
// gray bytes, as set by source_format (0 YUV 4:2:2 with shared U/V and CCIR 601
// coefficients, 1 RGB555, 2 RGB888, 3 gives all zero) and gray_output. One item is taken
// every clock while in_stall is low; each result passes through the coefficient multiply
// stage in each pixel lane and then the output register. The
// output register lets a new item enter while a result waits on out_stall. Write the
// configuration only while no items are in flight.
module capture_pixel_format_converter_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_index,
	input  logic [cpfc_pkg::CfgW-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [cpfc_pkg::PixW-1:0]  first_source_pixel,
	input  logic [cpfc_pkg::PixW-1:0]  second_source_pixel,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cpfc_pkg::ChanW-1:0] blue_first,
	output logic [cpfc_pkg::ChanW-1:0] green_first,
	output logic [cpfc_pkg::ChanW-1:0] red_first,
	output logic [cpfc_pkg::ChanW-1:0] blue_second,
	output logic [cpfc_pkg::ChanW-1:0] green_second,
	output logic [cpfc_pkg::ChanW-1:0] red_second,
	output logic [cpfc_pkg::ChanW-1:0] gray_first,
	output logic [cpfc_pkg::ChanW-1:0] gray_second
);

	cpfc_pkg::fmt_t   source_format_q;
	logic             gray_output_q;
	logic             valid_s1;
	logic             s1_en;
	logic             s2_free;
	cpfc_pkg::pixel_t pix_first;
	cpfc_pkg::pixel_t pix_second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= cpfc_pkg::FMT_YUV422;
			gray_output_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cpfc_pkg::CFG_SOURCE_FORMAT: source_format_q <= cpfc_pkg::fmt_t'(cfg_data);
				cpfc_pkg::CFG_GRAY_OUTPUT:   gray_output_q   <= cfg_data[0];
				default: begin
					gray_output_q <= gray_output_q;
				end
			endcase
		end
	end

	assign s1_en    = !valid_s1 || s2_free;
	assign in_stall = !s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= in_valid;
		end
	end

	// both lanes share U from the first word and V from the second
	cpfc_lane u_lane_first (
		.clk    (clk),
		.load   (s1_en && in_valid),
		.word   (first_source_pixel),
		.u_byte (first_source_pixel[15:8]),
		.v_byte (second_source_pixel[15:8]),
		.fmt    (source_format_q),
		.gray   (gray_output_q),
		.pix    (pix_first)
	);

	cpfc_lane u_lane_second (
		.clk    (clk),
		.load   (s1_en && in_valid),
		.word   (second_source_pixel),
		.u_byte (first_source_pixel[15:8]),
		.v_byte (second_source_pixel[15:8]),
		.fmt    (source_format_q),
		.gray   (gray_output_q),
		.pix    (pix_second)
	);

	cpfc_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (valid_s1),
		.pix_first    (pix_first),
		.pix_second   (pix_second),
		.out_stall    (out_stall),
		.s2_free      (s2_free),
		.out_valid    (out_valid),
		.blue_first   (blue_first),
		.green_first  (green_first),
		.red_first    (red_first),
		.blue_second  (blue_second),
		.green_second (green_second),
		.red_second   (red_second),
		.gray_first   (gray_first),
		.gray_second  (gray_second)
	);

endmodule

@@ tb/tb_capture_pixel_format_converter_unit.sv @@
module tb_capture_pixel_format_converter_unit;

	typedef logic [cpfc_pkg::ChanW-1:0][cpfc_pkg::ChanW-1:0] pixel_pair_t;

	localparam int CycleLimit = 200000;
	localparam int PhaseItems = 60;
	localparam int DrainCycles = 6;

	class pair_scoreboard;
		logic [cpfc_pkg::CfgW-1:0] src_fmt;
		logic                      gray_mode;
		pixel_pair_t               awaited[$];
		int                        errors;
		string                     field_names[8] = '{"blue_first", "green_first",
			"red_first", "blue_second", "green_second", "red_second", "gray_first",
			"gray_second"};

		function new();
			src_fmt = cpfc_pkg::FMT_YUV422;
			gray_mode = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(cpfc_pkg::cfg_idx_t idx, logic [cpfc_pkg::CfgW-1:0] value);
			if (idx == cpfc_pkg::CFG_SOURCE_FORMAT) begin
				src_fmt = value;
			end else begin
				gray_mode = value[0];
			end
		endfunction

		function logic [cpfc_pkg::ChanW-1:0] clamp_chan(int x);
			if (x < 0)
				return '0;
			if (x > 255)
				return cpfc_pkg::ChanMax;
			return x[cpfc_pkg::ChanW-1:0];
		endfunction

		function void yuv_pixel(logic [cpfc_pkg::ChanW-1:0] y, int u, int v,
				output logic [cpfc_pkg::ChanW-1:0] b,
				output logic [cpfc_pkg::ChanW-1:0] g,
				output logic [cpfc_pkg::ChanW-1:0] r);
			int luma;
			int s;
			luma = int'(y);
			if (luma < int'(cpfc_pkg::YMin))
				luma = int'(cpfc_pkg::YMin);
			if (luma > int'(cpfc_pkg::YMax))
				luma = int'(cpfc_pkg::YMax);
			s = luma * 1024;
			r = clamp_chan((s + 1404 * v) / 1024);
			g = clamp_chan((s - 715 * v - 344 * u) / 1024);
			b = clamp_chan((s + 1774 * u) / 1024);
		endfunction

		function pixel_pair_t convert(logic [cpfc_pkg::PixW-1:0] p1,
				logic [cpfc_pkg::PixW-1:0] p2);
			pixel_pair_t res;
			logic [cpfc_pkg::ChanW-1:0] b, g, r;
			int u, v;
			res = '0;
			case (src_fmt)
				cpfc_pkg::FMT_YUV422: begin
					if (gray_mode) begin
						res[6] = p1[7:0];
						res[7] = p2[7:0];
					end else begin
						u = int'(p1[15:8]) - 128;
						v = int'(p2[15:8]) - 128;
						yuv_pixel(p1[7:0], u, v, b, g, r);
						res[0] = b;
						res[1] = g;
						res[2] = r;
						yuv_pixel(p2[7:0], u, v, b, g, r);
						res[3] = b;
						res[4] = g;
						res[5] = r;
					end
				end
				cpfc_pkg::FMT_RGB555: begin
					if (gray_mode) begin
						res[6] = {p1[14:10], 3'b000};
						res[7] = {p2[14:10], 3'b000};
					end else begin
						res[0] = {p1[4:0], 3'b000};
						res[1] = {p1[9:5], 3'b000};
						res[2] = {p1[14:10], 3'b000};
						res[3] = {p2[4:0], 3'b000};
						res[4] = {p2[9:5], 3'b000};
						res[5] = {p2[14:10], 3'b000};
					end
				end
				cpfc_pkg::FMT_RGB888: begin
					if (gray_mode) begin
						res[6] = p1[7:0];
						res[7] = p2[7:0];
					end else begin
						res[0] = p1[7:0];
						res[1] = p1[15:8];
						res[2] = p1[23:16];
						res[3] = p2[7:0];
						res[4] = p2[15:8];
						res[5] = p2[23:16];
					end
				end
				default: begin
				end
			endcase
			return res;
		endfunction

		function void note_input(logic [cpfc_pkg::PixW-1:0] p1,
				logic [cpfc_pkg::PixW-1:0] p2);
			awaited.push_back(convert(p1, p2));
		endfunction

		function void check_result(pixel_pair_t got);
			pixel_pair_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %h arrived with no item pending", got);
				return;
			end
			want = awaited.pop_front();
			for (int i = 0; i < 8; i++) begin
				if (got[i] !== want[i]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch on %s: expected %h, got %h (fmt %0d gray %0b)",
							field_names[i], want[i], got[i], src_fmt, gray_mode);
				end
			end
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic                             cfg_index = 1'b0;
	logic [cpfc_pkg::CfgW-1:0]        cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [cpfc_pkg::PixW-1:0]        first_source_pixel = '0;
	logic [cpfc_pkg::PixW-1:0]        second_source_pixel = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [cpfc_pkg::ChanW-1:0]       blue_first, green_first, red_first;
	logic [cpfc_pkg::ChanW-1:0]       blue_second, green_second, red_second;
	logic [cpfc_pkg::ChanW-1:0]       gray_first, gray_second;

	pair_scoreboard score = new();
	int cycles = 0;
	int burst_left = 0;
	int stall_span = 0;
	int stall_pct = 0;

	capture_pixel_format_converter_unit DUT (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("capture_pixel_format_converter_unit test failed");
			$finish;
		end
	end

	// receiver: stall density changes over time among four levels, sometimes none at all
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_span = $urandom_range(16, 96);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		stall_span--;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			score.check_result({gray_second, gray_first, red_second, green_second,
				blue_second, red_first, green_first, blue_first});
	end

	function automatic logic [cpfc_pkg::PixW-1:0] random_pixel();
		logic [31:0]               rnd;
		logic [cpfc_pkg::PixW-1:0] p;
		rnd = $urandom;
		p = rnd[cpfc_pkg::PixW-1:0];
		case ($urandom_range(0, 7))
			0: p[7:0] = 8'($urandom_range(0, 20));
			1: p[7:0] = 8'($urandom_range(230, 255));
			2: p[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: begin
			end
		endcase
		return p;
	endfunction

	task automatic send_item(logic [cpfc_pkg::PixW-1:0] a, logic [cpfc_pkg::PixW-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		first_source_pixel <= a;
		second_source_pixel <= b;
		do
			@(posedge clk);
		while (in_stall);
		score.note_input(a, b);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (score.awaited.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic apply_setting(logic [cpfc_pkg::CfgW-1:0] fmt, logic gray);
		cfg_wr_en <= 1'b1;
		cfg_index <= cpfc_pkg::CFG_SOURCE_FORMAT;
		cfg_data <= fmt;
		score.set_reg(cpfc_pkg::CFG_SOURCE_FORMAT, fmt);
		@(negedge clk);
		cfg_index <= cpfc_pkg::CFG_GRAY_OUTPUT;
		cfg_data <= {1'b0, gray};
		score.set_reg(cpfc_pkg::CFG_GRAY_OUTPUT, {1'b0, gray});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [cpfc_pkg::CfgW-1:0] fmt_sel;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		// every format including the undefined one, each in color and gray mode
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			fmt_sel = ph[cpfc_pkg::CfgW:1];
			apply_setting(fmt_sel, ph[0]);
			send_item(24'h000000, 24'h000000);
			send_item(24'hFFFFFF, 24'hFFFFFF);
			// luma below and above the clamp range, chroma at both ends, ignored bits set
			send_item(24'h00000F, 24'h80FFEC);
			repeat (PhaseItems) send_item(random_pixel(), random_pixel());
		end
		drain();
		if (score.errors == 0 && score.awaited.size() == 0) begin
			$display("capture_pixel_format_converter_unit test passed");
		end else begin
			$display("capture_pixel_format_converter_unit test failed");
		end
		$finish;
	end

endmodule
